[hdl/vgs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vgs_pkg;

  localparam int VGS_MAX_X = 32;
  localparam int VGS_MAX_Y = 32;
  localparam int VGS_MAX_Z = 32;

  localparam int VGS_VALUE_W = 16;
  localparam int VGS_COORD_W = 11;
  localparam int VGS_SIZE_W  = 6;
  localparam int VGS_PADDR_W = 4;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FILL  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PREP,
    ST_START,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic sweep;
    logic prep;
    logic start;
    logic walk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic walk_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[hdl/vgs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module vgs_ram #(
  parameter int Width = 16,
  parameter int Depth = 32768,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AddrW-1:0] addr,
  input  wire logic [Width-1:0] wdata,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[hdl/vgs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module vgs_datapath
  import vgs_pkg::*;
#(
  parameter int MAX_X = VGS_MAX_X,
  parameter int MAX_Y = VGS_MAX_Y,
  parameter int MAX_Z = VGS_MAX_Z
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cmd_t                          cmd,
  output status_t                            status,
  input  wire logic [1:0]                    action,
  input  wire logic signed [VGS_COORD_W-1:0] xa,
  input  wire logic signed [VGS_COORD_W-1:0] ya,
  input  wire logic signed [VGS_COORD_W-1:0] za,
  input  wire logic signed [VGS_COORD_W-1:0] xb,
  input  wire logic signed [VGS_COORD_W-1:0] yb,
  input  wire logic signed [VGS_COORD_W-1:0] zb,
  input  wire logic [VGS_VALUE_W-1:0]        write_value,
  input  wire logic [VGS_SIZE_W-1:0]         size_x,
  input  wire logic [VGS_SIZE_W-1:0]         size_y,
  input  wire logic [VGS_SIZE_W-1:0]         size_z,
  output logic [VGS_VALUE_W-1:0]             read_value,
  output logic                               ok,
  output logic                               out_valid,
  input  wire logic                          out_stall
);

  localparam int Depth   = MAX_X * MAX_Y * MAX_Z;
  localparam int AW      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int XW      = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int YW      = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW      = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int StrideZ = MAX_X * MAX_Y;
  localparam logic [AW-1:0] StepY    = AW'(MAX_X);
  localparam logic [AW-1:0] StepZ    = AW'(StrideZ);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  // Working width: one bit above the coordinate so that ordering and
  // clamping never overflow.
  localparam int RW = VGS_COORD_W + 1;

  typedef struct packed {
    logic [RW-1:0] lo;
    logic [RW-1:0] hi;
  } range_t;

  // Picks the corner pair for the action, orders it and clamps it to
  // [0, eff-1]. The range is empty when lo ends above hi.
  function automatic range_t axis_range(input logic [1:0] act,
                                        input logic signed [VGS_COORD_W-1:0] a,
                                        input logic signed [VGS_COORD_W-1:0] b,
                                        input logic [VGS_SIZE_W-1:0] eff);
    logic signed [RW-1:0] p;
    logic signed [RW-1:0] q;
    logic signed [RW-1:0] lo;
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] top;
    range_t r;
    top = $signed({{(RW-VGS_SIZE_W){1'b0}}, eff}) - $signed(RW'(1));
    if (act == ACT_CLEAR) begin
      p = '0;
      q = top;
    end else if (act == ACT_FILL) begin
      p = $signed({a[VGS_COORD_W-1], a});
      q = $signed({b[VGS_COORD_W-1], b});
    end else begin
      p = $signed({a[VGS_COORD_W-1], a});
      q = p;
    end
    if (p > q) begin
      lo = q;
      hi = p;
    end else begin
      lo = p;
      hi = q;
    end
    if (lo < 0) begin
      lo = '0;
    end
    if (hi > top) begin
      hi = top;
    end
    r.lo = lo;
    r.hi = hi;
    return r;
  endfunction

  // Item registers.
  logic [1:0]                    act;
  logic signed [VGS_COORD_W-1:0] xa_r, ya_r, za_r, xb_r, yb_r, zb_r;
  logic [VGS_VALUE_W-1:0]        value;

  // Box registers.
  logic [XW-1:0] x_lo, x_hi, x;
  logic [YW-1:0] y_lo, y_hi, y;
  logic [ZW-1:0] z_lo, z_hi, z;
  logic          empty;

  logic [AW-1:0] addr, row_addr, plane_addr;
  logic [AW-1:0] start_addr;
  logic [AW-1:0] sweep_addr;

  logic [VGS_SIZE_W-1:0] eff_x, eff_y, eff_z;
  range_t                rx, ry, rz;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_addr;
  logic [VGS_VALUE_W-1:0] ram_wdata, ram_rdata;
  logic                   x_end, y_end, z_end;
  logic                   is_read;

  // An extent above the maximum acts as the maximum.
  assign eff_x = ({3'b0, size_x} > 9'(MAX_X)) ? VGS_SIZE_W'(MAX_X) : size_x;
  assign eff_y = ({3'b0, size_y} > 9'(MAX_Y)) ? VGS_SIZE_W'(MAX_Y) : size_y;
  assign eff_z = ({3'b0, size_z} > 9'(MAX_Z)) ? VGS_SIZE_W'(MAX_Z) : size_z;

  assign rx = axis_range(act, xa_r, xb_r, eff_x);
  assign ry = axis_range(act, ya_r, yb_r, eff_y);
  assign rz = axis_range(act, za_r, zb_r, eff_z);

  assign start_addr = AW'(x_lo) + AW'(int'(y_lo) * MAX_X) + AW'(int'(z_lo) * StrideZ);

  assign is_read = (act == ACT_READ);
  assign x_end   = (x == x_hi);
  assign y_end   = (y == y_hi);
  assign z_end   = (z == z_hi);

  assign status.sweep_last = (sweep_addr == LastAddr);
  assign status.walk_last  = empty || (x_end && y_end && z_end);
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= action;
      xa_r  <= xa;
      ya_r  <= ya;
      za_r  <= za;
      xb_r  <= xb;
      yb_r  <= yb;
      zb_r  <= zb;
      value <= write_value;
    end
    if (cmd.prep) begin
      x_lo  <= XW'(rx.lo);
      x_hi  <= XW'(rx.hi);
      y_lo  <= YW'(ry.lo);
      y_hi  <= YW'(ry.hi);
      z_lo  <= ZW'(rz.lo);
      z_hi  <= ZW'(rz.hi);
      empty <= ($signed(rx.lo) > $signed(rx.hi)) ||
               ($signed(ry.lo) > $signed(ry.hi)) ||
               ($signed(rz.lo) > $signed(rz.hi));
    end
    if (cmd.start) begin
      x          <= x_lo;
      y          <= y_lo;
      z          <= z_lo;
      addr       <= start_addr;
      row_addr   <= start_addr;
      plane_addr <= start_addr;
    end else if (cmd.walk && !status.walk_last) begin
      // Raster order: x fastest, then y, then z; addresses follow by adds.
      if (!x_end) begin
        x    <= x + XW'(1);
        addr <= addr + AW'(1);
      end else if (!y_end) begin
        x        <= x_lo;
        y        <= y + YW'(1);
        row_addr <= row_addr + StepY;
        addr     <= row_addr + StepY;
      end else begin
        x          <= x_lo;
        y          <= y_lo;
        z          <= z + ZW'(1);
        plane_addr <= plane_addr + StepZ;
        row_addr   <= plane_addr + StepZ;
        addr       <= plane_addr + StepZ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep && !status.sweep_last) begin
      sweep_addr <= sweep_addr + AW'(1);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = addr;
    ram_wdata = value;
    if (cmd.sweep) begin
      ram_we    = 1'b1;
      ram_addr  = sweep_addr;
      ram_wdata = '0;
    end else if (cmd.walk && !empty) begin
      ram_we = !is_read;
      ram_re = is_read;
    end
  end

  vgs_ram #(
    .Width(VGS_VALUE_W),
    .Depth(Depth)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_value <= (is_read && !empty) ? ram_rdata : '0;
      ok         <= !(empty && (is_read || act == ACT_WRITE));
    end
  end

endmodule

`default_nettype wire

[hdl/vgs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module vgs_ctrl
  import vgs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_SWEEP:  if (status.sweep_last) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_PREP;
      ST_PREP:   state_next = ST_START;
      ST_START:  state_next = ST_WALK;
      ST_WALK:   if (status.walk_last) state_next = ST_FINISH;
      ST_FINISH: if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_SWEEP;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_SWEEP: cmd.sweep = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_PREP:   cmd.prep   = 1'b1;
      ST_START:  cmd.start  = 1'b1;
      ST_WALK:   cmd.walk   = 1'b1;
      ST_FINISH: cmd.finish = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/voxel_grid_store.sv]
`timescale 1ns / 1ps
`default_nettype none

// Voxel grid store: a MAX_X x MAX_Y x MAX_Z array of 16-bit block ids with
// run-time extents size_x/y/z (APB registers at 0x0, 0x4, 0x8). Voxel
// (x,y,z) sits at word x + y*MAX_X + z*MAX_X*MAX_Y of one single-port RAM,
// so resizing never moves data. After reset the block zeroes all
// MAX_X*MAX_Y*MAX_Z words of the RAM (32768 by default) one word per
// cycle, and holds in_stall high until done. Each item is then walked
// through a sequencer: accept, order and clamp the box, form the start
// address, access each voxel written or read in turn (none for an empty
// box), and load the result register. The result waits in an output
// register, and the next item may be accepted while it is still stalled.
module voxel_grid_store
  import vgs_pkg::*;
#(
  parameter int MAX_X = VGS_MAX_X,
  parameter int MAX_Y = VGS_MAX_Y,
  parameter int MAX_Z = VGS_MAX_Z
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [VGS_PADDR_W-1:0]        paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    action,
  input  wire logic signed [VGS_COORD_W-1:0] xa,
  input  wire logic signed [VGS_COORD_W-1:0] ya,
  input  wire logic signed [VGS_COORD_W-1:0] za,
  input  wire logic signed [VGS_COORD_W-1:0] xb,
  input  wire logic signed [VGS_COORD_W-1:0] yb,
  input  wire logic signed [VGS_COORD_W-1:0] zb,
  input  wire logic [VGS_VALUE_W-1:0]        write_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [VGS_VALUE_W-1:0]             read_value,
  output logic                               ok
);

  logic [VGS_SIZE_W-1:0] size_x, size_y, size_z;
  logic                  reg_write;
  reg_index_t            reg_index;
  cmd_t                  cmd;
  status_t               status;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign reg_index = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= VGS_SIZE_W'(32);
      size_y <= VGS_SIZE_W'(32);
      size_z <= VGS_SIZE_W'(32);
    end else if (reg_write) begin
      unique case (reg_index)
        REG_SIZE_X: size_x <= pwdata[VGS_SIZE_W-1:0];
        REG_SIZE_Y: size_y <= pwdata[VGS_SIZE_W-1:0];
        REG_SIZE_Z: size_z <= pwdata[VGS_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_SIZE_X: prdata = {{(32-VGS_SIZE_W){1'b0}}, size_x};
      REG_SIZE_Y: prdata = {{(32-VGS_SIZE_W){1'b0}}, size_y};
      REG_SIZE_Z: prdata = {{(32-VGS_SIZE_W){1'b0}}, size_z};
      default:    prdata = '0;
    endcase
  end

  vgs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  vgs_datapath #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y),
    .MAX_Z(MAX_Z)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .action     (action),
    .xa         (xa),
    .ya         (ya),
    .za         (za),
    .xb         (xb),
    .yb         (yb),
    .zb         (zb),
    .write_value(write_value),
    .size_x     (size_x),
    .size_y     (size_y),
    .size_z     (size_z),
    .read_value (read_value),
    .ok         (ok),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule

`default_nettype wire
